// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl file plid_back.sv
// no dependencies; every check is clocked on a rising edge and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: ante |-> cons");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: ante |=> cons");

`endif

// ===== sv/plid_pkg.sv =====
// types, codes and widths shared by the list front end, queue and back end
// no dependencies
package plid_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int QDEPTH    = 4;
   localparam int VAL_W     = 32;
   localparam int POS_W     = 8;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;

   typedef enum logic [2:0] {
      OP_BEGIN  = 3'd0,
      OP_LOAD   = 3'd1,
      OP_READ   = 3'd2,
      OP_INSERT = 3'd3,
      OP_UPDATE = 3'd4,
      OP_DELETE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_BADPOS  = 3'd3,
      ST_BADLEN  = 3'd4,
      ST_BADOP   = 3'd5,
      ST_PENDING = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      K_NONE,
      K_WRITE,
      K_READ,
      K_INSERT,
      K_DELETE
   } kind_type;

   // one classified operation handed from front to back
   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [CNT_W-1:0]  count;
      logic [IDX_W-1:0]  addr;
      logic [VAL_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== sv/plid_front.sv =====
// front end: tracks list length and load progress, classifies each accepted item
// depends on plid_pkg
module plid_front #(
   parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [2:0]                 op,
   input  logic [plid_pkg::POS_W-1:0] pos,
   input  logic [plid_pkg::POS_W-1:0] len,
   input  logic [plid_pkg::VAL_W-1:0] value,
   output plid_pkg::cmd_type          cmd
);
   import plid_pkg::*;

   logic [CNT_W-1:0] list_ff, list_in;
   logic [CNT_W-1:0] lptr_ff, lptr_in;
   logic [CNT_W-1:0] ltgt_ff, ltgt_in;
   logic             pending;
   logic [POS_W-1:0] list_ext;
   logic [POS_W-1:0] pos_m1;

   assign pending  = lptr_ff < ltgt_ff;
   assign list_ext = POS_W'(list_ff);
   assign pos_m1   = pos - POS_W'(1);

   always_comb begin
      list_in    = list_ff;
      lptr_in    = lptr_ff;
      ltgt_in    = ltgt_ff;
      cmd.kind   = K_NONE;
      cmd.status = ST_OK;
      cmd.addr   = '0;
      cmd.value  = value;
      priority if (op == OP_BEGIN) begin
         list_in = '0;
         lptr_in = '0;
         if (len > POS_W'(DEPTH)) begin
            ltgt_in    = '0;
            cmd.status = ST_BADLEN;
         end else begin
            ltgt_in = len[CNT_W-1:0];
         end
      end else if (op == OP_LOAD) begin
         if (!pending) begin
            cmd.status = ST_BADOP;
         end else begin
            cmd.kind = K_WRITE;
            cmd.addr = lptr_ff[IDX_W-1:0];
            lptr_in  = lptr_ff + CNT_W'(1);
            if (lptr_in >= ltgt_ff) list_in = ltgt_ff;
         end
      end else if (pending) begin
         cmd.status = ST_PENDING;
      end else if (op > OP_DELETE) begin
         cmd.status = ST_BADOP;
      end else if (list_ff == '0) begin
         cmd.status = ST_EMPTY;
      end else if (op == OP_READ) begin
         cmd.kind = K_READ;
      end else if (op == OP_INSERT) begin
         if (list_ff >= CNT_W'(DEPTH)) begin
            cmd.status = ST_FULL;
         end else if (pos == '0 || pos > list_ext + POS_W'(1)) begin
            cmd.status = ST_BADPOS;
         end else begin
            cmd.kind = K_INSERT;
            cmd.addr = pos_m1[IDX_W-1:0];
            list_in  = list_ff + CNT_W'(1);
         end
      end else if (pos == '0 || pos > list_ext) begin
         cmd.status = ST_BADPOS;
      end else if (op == OP_UPDATE) begin
         cmd.kind = K_WRITE;
         cmd.addr = pos_m1[IDX_W-1:0];
      end else begin
         cmd.kind = K_DELETE;
         cmd.addr = pos_m1[IDX_W-1:0];
         list_in  = list_ff - CNT_W'(1);
      end
      cmd.count = list_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_ff <= '0;
         lptr_ff <= '0;
         ltgt_ff <= '0;
      end else if (accept) begin
         list_ff <= list_in;
         lptr_ff <= lptr_in;
         ltgt_ff <= ltgt_in;
      end
   end

endmodule

// ===== sv/plid_queue.sv =====
// short command queue between the front end and the back end
// depends on plid_pkg
module plid_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  plid_pkg::cmd_type push_cmd,
   input  logic              pop,
   output plid_pkg::cmd_type head,
   output plid_pkg::qstat_type stat
);
   import plid_pkg::*;

   localparam int PW = $clog2(QDEPTH);

   cmd_type         slot_ff [QDEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in;
   logic [PW-1:0]   rptr_ff, rptr_in;
   logic [PW:0]     fill_ff, fill_in;

   assign stat.full  = fill_ff == (PW+1)'(QDEPTH);
   assign stat.empty = fill_ff == '0;
   assign head       = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in = pop  ? rptr_ff + PW'(1) : rptr_ff;
      fill_in = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sv/plid_back.sv =====
// back end: element memory, shift sequencer, read-out and the response register
// depends on plid_pkg and assert_macros.svh
`include "assert_macros.svh"

module plid_back #(
   parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  plid_pkg::cmd_type          q_head,
   input  plid_pkg::qstat_type        q_stat,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [2:0]                 rsp_status,
   output logic [plid_pkg::VAL_W-1:0] rsp_element,
   output logic [plid_pkg::IDX_W-1:0] rsp_index,
   output logic [plid_pkg::CNT_W-1:0] rsp_count,
   output logic                       rsp_last
);
   import plid_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_SHIFT} state_type;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rdata_ff;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [AW-1:0]    prev_ff, prev_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             have_ff, have_in;
   logic [AW-1:0]    idx_ff, idx_in;

   logic             oval_ff, oval_in;
   status_type       ost_ff, ost_in;
   logic [VAL_W-1:0] oelem_ff, oelem_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   logic [CNT_W-1:0] ocnt_ff, ocnt_in;
   logic             olast_ff, olast_in;

   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic             out_free;
   logic             rd_last;
   logic [AW-1:0]    head_addr;

   assign out_free  = !oval_ff || rsp_tready;
   assign rd_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == cmd_ff.count;
   assign head_addr = q_head.addr[AW-1:0];

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      ptr_in   = ptr_ff;
      prev_in  = prev_ff;
      left_in  = left_ff;
      have_in  = have_ff;
      idx_in   = idx_ff;
      oval_in  = oval_ff && !rsp_tready;
      ost_in   = ost_ff;
      oelem_in = oelem_ff;
      oidx_in  = oidx_ff;
      ocnt_in  = ocnt_ff;
      olast_in = olast_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty && out_free) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               if (q_head.kind != K_READ) begin
                  // single response for everything but read all
                  oval_in  = 1'b1;
                  ost_in   = q_head.status;
                  oelem_in = '0;
                  oidx_in  = '0;
                  ocnt_in  = q_head.count;
                  olast_in = 1'b1;
               end
               have_in = 1'b0;
               unique case (q_head.kind)
                  K_NONE: ;
                  K_WRITE: begin
                     wr_en   = 1'b1;
                     wr_addr = head_addr;
                     wr_data = q_head.value;
                  end
                  K_READ: begin
                     rd_en    = 1'b1;
                     idx_in   = '0;
                     state_in = S_READ;
                  end
                  K_INSERT: begin
                     // move old slots count-2 down to addr up by one
                     left_in  = q_head.count - CNT_W'(1) - CNT_W'(q_head.addr);
                     ptr_in   = AW'(q_head.count - CNT_W'(2));
                     state_in = S_SHIFT;
                  end
                  K_DELETE: begin
                     // move slots addr+1 up to old end down by one
                     left_in  = q_head.count - CNT_W'(q_head.addr);
                     ptr_in   = head_addr + AW'(1);
                     state_in = S_SHIFT;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               oval_in  = 1'b1;
               ost_in   = ST_OK;
               oelem_in = rdata_ff;
               oidx_in  = IDX_W'(idx_ff);
               ocnt_in  = cmd_ff.count;
               olast_in = rd_last;
               if (rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end
         S_SHIFT: begin
            if (have_ff) begin
               wr_en   = 1'b1;
               wr_addr = (cmd_ff.kind == K_INSERT) ? prev_ff + AW'(1) : prev_ff - AW'(1);
               wr_data = rdata_ff;
            end
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff;
               prev_in = ptr_ff;
               ptr_in  = (cmd_ff.kind == K_INSERT) ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
               left_in = left_ff - CNT_W'(1);
               have_in = 1'b1;
            end else begin
               have_in = 1'b0;
            end
            if (left_ff == '0 && !have_ff) begin
               // shift done; for an insert, drop the new value into its slot
               if (cmd_ff.kind == K_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = cmd_ff.addr[AW-1:0];
                  wr_data = cmd_ff.value;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         oval_ff  <= 1'b0;
         have_ff  <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         oval_ff  <= oval_in;
         have_ff  <= have_in;
         left_ff  <= left_in;
      end
      cmd_ff   <= cmd_in;
      ptr_ff   <= ptr_in;
      prev_ff  <= prev_in;
      idx_ff   <= idx_in;
      ost_ff   <= ost_in;
      oelem_ff <= oelem_in;
      oidx_ff  <= oidx_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid  = oval_ff;
   assign rsp_status  = ost_ff;
   assign rsp_element = oelem_ff;
   assign rsp_index   = oidx_ff;
   assign rsp_count   = ocnt_ff;
   assign rsp_last    = olast_ff;

   `CHK_NOW(a_no_rw_clash, clock, reset, rd_en && wr_en, rd_addr != wr_addr)
   `CHK_NOW(a_read_no_write, clock, reset, state_ff == S_READ, !wr_en)
   `CHK_NEXT(a_shift_ends, clock, reset,
             state_ff == S_SHIFT && left_ff == '0 && !have_ff, state_ff == S_IDLE)

endmodule

// ===== sv/positional_list_insert_delete_top.sv =====
// top level of the positional list: front end, command queue and back end
// depends on plid_pkg, plid_front, plid_queue and plid_back
//
// usage:
//   req channel carries one operation per transfer: begin load, load element,
//   read all, insert, update or delete. rsp channel returns one result per
//   operation, or one per element for a successful read all, with rsp_tlast
//   on the final result of each operation.
//   the front end checks and classifies an operation in the cycle it is
//   accepted; a four-entry queue holds classified operations for the back end.
//   throughput: begin load, load, update and error results 1 per cycle, and
//   read all 1 element per cycle, as long as rsp_tready stays high; insert
//   and delete move the elements one at a time, as the element memory has a
//   single read port and a single write port, and the back end takes no new
//   operation until the shift is done.
//   reset clears list length and load state; element storage is not cleared.
//   a stalled rsp_tready holds the result register; the queue keeps taking
//   operations until it fills, then req_tready drops.
module positional_list_insert_delete_top #(
   parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // position[7:0], length[15:8], value[47:16]
   input  logic [2:0]  req_tuser,  // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // element[31:0], element_index[37:32], count[44:38], zero
   output logic [2:0]  rsp_tuser,  // status[2:0]
   output logic        rsp_tlast
);
   import plid_pkg::*;

   cmd_type          f_cmd;
   cmd_type          q_head;
   qstat_type        q_stat;
   logic             q_pop;
   logic             accept;
   logic [VAL_W-1:0] element;
   logic [IDX_W-1:0] index;
   logic [CNT_W-1:0] count;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   plid_front #(.DEPTH(DEPTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .op     (req_tuser),
      .pos    (req_tdata[7:0]),
      .len    (req_tdata[15:8]),
      .value  (req_tdata[47:16]),
      .cmd    (f_cmd)
   );

   plid_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (f_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   plid_back #(.DEPTH(DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_stat      (q_stat),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_element (element),
      .rsp_index   (index),
      .rsp_count   (count),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, count, index, element};

endmodule

// ===== tb/sv/plid_list_checker.sv =====
`timescale 1ns / 100ps
// result checker for the positional list: predicts every result from the accepted operations
// and compares each result transfer with the oldest prediction; depends on plid_pkg
module plid_list_checker #(
   parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,  // position[7:0], length[15:8], value[47:16]
   input  logic [2:0]  req_tuser,  // opcode[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,  // element[31:0], element_index[37:32], count[44:38], zero
   input  logic [2:0]  rsp_tuser,  // status[2:0]
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          results_due,
   output int          list_size,
   output int          results_seen
);
   import plid_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [2:0]  pad;
      logic [31:0] element;
      logic [5:0]  element_index;
      logic [6:0]  count;
      logic        last;
   } list_result_t;

   list_result_t result_q[$];
   logic [31:0]  slot_mem [0:DEPTH-1];
   int           list_len;
   int           load_ptr;
   int           load_tgt;

   initial begin
      mismatch_count = 0;
      results_due    = 0;
      list_size      = 0;
      results_seen   = 0;
   end

   function automatic void push_result(input status_type st, input logic [31:0] elem,
                                       input int idx, input bit last);
      list_result_t r;
      r.status        = st;
      r.pad           = '0;
      r.element       = elem;
      r.element_index = idx[5:0];
      r.count         = list_len[6:0];
      r.last          = last;
      result_q.push_back(r);
   endfunction

   task automatic apply_op(input logic [2:0] op, input int pos, input int len,
                           input logic [31:0] val);
      status_type st;
      bit         loading;
      int         i;
      st      = ST_OK;
      loading = load_ptr < load_tgt;
      if (op == OP_BEGIN) begin
         list_len = 0;
         load_ptr = 0;
         if (len > DEPTH) begin
            load_tgt = 0;
            st       = ST_BADLEN;
         end else begin
            load_tgt = len;
         end
      end else if (op == OP_LOAD) begin
         if (!loading) begin
            st = ST_BADOP;
         end else begin
            slot_mem[load_ptr] = val;
            load_ptr++;
            if (load_ptr >= load_tgt) list_len = load_tgt;
         end
      end else if (loading) begin
         st = ST_PENDING;
      end else if (op > OP_DELETE) begin
         st = ST_BADOP;
      end else if (list_len == 0) begin
         st = ST_EMPTY;
      end else if (op == OP_READ) begin
         for (i = 0; i < list_len; i++)
            push_result(ST_OK, slot_mem[i], i, i == list_len - 1);
         return;
      end else if (op == OP_INSERT) begin
         if (list_len >= DEPTH) begin
            st = ST_FULL;
         end else if (pos < 1 || pos > list_len + 1) begin
            st = ST_BADPOS;
         end else begin
            for (i = list_len; i >= pos; i--) slot_mem[i] = slot_mem[i-1];
            slot_mem[pos-1] = val;
            list_len++;
         end
      end else if (op == OP_UPDATE) begin
         if (pos < 1 || pos > list_len) st = ST_BADPOS;
         else slot_mem[pos-1] = val;
      end else begin
         if (pos < 1 || pos > list_len) begin
            st = ST_BADPOS;
         end else begin
            for (i = pos - 1; i + 1 < list_len; i++) slot_mem[i] = slot_mem[i+1];
            list_len--;
         end
      end
      push_result(st, '0, 0, 1'b1);
   endtask

   always @(posedge clock) begin
      list_result_t want;
      list_result_t got;
      if (reset) begin
         list_len = 0;
         load_ptr = 0;
         load_tgt = 0;
         result_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status        = status_type'(rsp_tuser);
            got.pad           = rsp_tdata[47:45];
            got.element       = rsp_tdata[31:0];
            got.element_index = rsp_tdata[37:32];
            got.count         = rsp_tdata[44:38];
            got.last          = rsp_tlast;
            results_seen++;
            if (result_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result transfer: status %0d element %h index %0d",
                        $time, got.status, got.element, got.element_index);
            end else begin
               want = result_q.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: expected status %0d element %h index %0d count %0d last %b pad %h",
                           $time, want.status, want.element, want.element_index, want.count,
                           want.last, want.pad);
                  $display("%0t:      got status %0d element %h index %0d count %0d last %b pad %h",
                           $time, got.status, got.element, got.element_index, got.count,
                           got.last, got.pad);
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_op(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[47:16]);
      end
      // registered so the stimulus side sees a settled value
      results_due <= result_q.size();
      list_size   <= list_len;
   end

endmodule

// ===== tb/sv/tb_positional_list_insert_delete_top.sv =====
`timescale 1ns / 100ps
// testbench top for the positional list: clock, reset, operation stimulus, result back-pressure
// depends on plid_pkg, positional_list_insert_delete_top and plid_list_checker
module tb_positional_list_insert_delete_top;
   import plid_pkg::*;

   localparam logic [2:0] OP_SPARE_LO    = 3'd6;
   localparam logic [2:0] OP_SPARE_HI    = 3'd7;
   localparam int         RX_HOLD_CYCLES = 300;
   localparam int         RANDOM_HALF    = 6;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // position[7:0], length[15:8], value[47:16]
   logic [2:0]  req_tuser;   // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // element[31:0], element_index[37:32], count[44:38], zero
   logic [2:0]  rsp_tuser;   // status[2:0]
   logic        rsp_tlast;

   int mismatch_count;
   int results_due;
   int list_size;
   int results_seen;
   int items_sent;
   int hold_left;
   int rx_stall;
   int rx_cycle;
   bit tx_burst;
   bit rx_calm;

   positional_list_insert_delete_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   plid_list_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .results_due    (results_due),
      .list_size      (list_size),
      .results_seen   (results_seen)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [7:0] pos,
                            input logic [7:0] len, input logic [31:0] val);
      if (!tx_burst && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {val, len, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // position mostly inside the list, sometimes anywhere in the field
   task automatic edit_op(input logic [2:0] op);
      logic [7:0] pos;
      if ($urandom_range(0, 9) == 0) pos = 8'($urandom());
      else pos = 8'($urandom_range(1, list_size + 1));
      send_item(op, pos, 8'($urandom()), $urandom());
   endtask

   // begin load then fill; a cut-short load is interrupted by another operation
   task automatic load_list(input int n, input bit cut_short);
      int stop;
      int i;
      stop = (cut_short && n > 0) ? $urandom_range(0, n - 1) : n;
      send_item(OP_BEGIN, 8'($urandom()), n[7:0], $urandom());
      for (i = 0; i < stop; i++) send_item(OP_LOAD, 8'($urandom()), 8'($urandom()), $urandom());
      if (stop < n) begin
         send_item(3'($urandom_range(OP_READ, OP_SPARE_HI)), 8'($urandom()), 8'($urandom()),
                   $urandom());
         if ($urandom_range(0, 1) == 0) load_list($urandom_range(1, 6), 1'b0);
      end
   endtask

   task automatic random_traffic(input int goal);
      int stop_at;
      int pick;
      int n;
      int k;
      stop_at = items_sent + goal;
      while (items_sent < stop_at) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         pick     = $urandom_range(0, 99);
         if (pick < 45) begin
            repeat ($urandom_range(1, 6)) begin
               k = $urandom_range(0, 9);
               if (k < 4) edit_op(OP_INSERT);
               else if (k < 6) edit_op(OP_UPDATE);
               else if (k < 9) edit_op(OP_DELETE);
               else edit_op(OP_READ);
            end
         end else if (pick < 70) begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 16);
            load_list(n, $urandom_range(0, 9) == 0);
         end else if (pick < 85) begin
            edit_op(OP_READ);
         end else begin
            send_item(3'($urandom_range(0, 7)), 8'($urandom()), 8'($urandom()), $urandom());
         end
      end
   endtask

   // result side: random stalls, calm stretches, and the long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle % 150 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 99) < 20) rx_stall = pick_gap();
         end
      end
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d results still due", results_due);
      $display("tb_positional_list_insert_delete_top failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_BEGIN;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty list, stray load, unused opcodes, bad lengths
      send_item(OP_READ,   8'd1,   8'd0,   $urandom());
      send_item(OP_INSERT, 8'd1,   8'd0,   $urandom());
      send_item(OP_UPDATE, 8'd1,   8'd0,   $urandom());
      send_item(OP_DELETE, 8'd1,   8'd0,   $urandom());
      send_item(OP_LOAD,   8'd0,   8'd0,   $urandom());
      send_item(OP_SPARE_LO, 8'd0, 8'd0,   $urandom());
      send_item(OP_SPARE_HI, 8'hff, 8'hff, 32'hffff_ffff);
      send_item(OP_BEGIN,  8'd0,   8'd255, $urandom());
      send_item(OP_BEGIN,  8'd0,   8'd65,  $urandom());
      send_item(OP_BEGIN,  8'd0,   8'd0,   $urandom());
      send_item(OP_READ,   8'd0,   8'd0,   $urandom());
      // a load interrupted, then dropped by a new begin load
      send_item(OP_BEGIN,  8'd0,   8'd3,   $urandom());
      send_item(OP_LOAD,   8'd0,   8'd0,   32'h8000_0000);
      send_item(OP_READ,   8'd0,   8'd0,   $urandom());
      send_item(OP_SPARE_HI, 8'd0, 8'd0,   $urandom());
      send_item(OP_BEGIN,  8'd0,   8'd2,   $urandom());
      send_item(OP_LOAD,   8'd0,   8'd0,   32'h7fff_ffff);
      send_item(OP_LOAD,   8'd0,   8'd0,   32'hffff_ffff);
      send_item(OP_READ,   8'd0,   8'd0,   $urandom());
      // positions at and beyond the edges
      send_item(OP_INSERT, 8'd0,   8'd0,   $urandom());
      send_item(OP_INSERT, 8'd255, 8'd0,   $urandom());
      send_item(OP_INSERT, 8'd3,   8'd0,   32'h0000_0000);
      send_item(OP_UPDATE, 8'd1,   8'd0,   32'h0000_0001);
      send_item(OP_DELETE, 8'd4,   8'd0,   $urandom());
      send_item(OP_DELETE, 8'd1,   8'd0,   $urandom());
      send_item(OP_READ,   8'd0,   8'd0,   $urandom());
      wait_drained();

      // list at capacity
      tx_burst = 1'b1;
      load_list(DEPTH_DEF, 1'b0);
      send_item(OP_INSERT, 8'd1,  8'd0, $urandom());
      send_item(OP_READ,   8'd0,  8'd0, $urandom());
      send_item(OP_UPDATE, 8'd64, 8'd0, $urandom());
      send_item(OP_DELETE, 8'd64, 8'd0, $urandom());
      send_item(OP_INSERT, 8'd64, 8'd0, $urandom());
      send_item(OP_INSERT, 8'd1,  8'd0, $urandom());
      send_item(OP_DELETE, 8'd1,  8'd0, $urandom());
      send_item(OP_UPDATE, 8'd65, 8'd0, $urandom());
      send_item(OP_READ,   8'd0,  8'd0, $urandom());
      wait_drained();

      random_traffic(RANDOM_HALF);

      // result side held off while operations keep coming, so the input stalls
      hold_left = RX_HOLD_CYCLES;
      tx_burst  = 1'b1;
      edit_op(OP_READ);
      repeat (8) edit_op(OP_UPDATE);
      wait_drained();

      random_traffic(RANDOM_HALF);
      wait_drained();
      repeat (DEPTH_DEF + 16) @(posedge clock);

      $display("run covered %0d operations and %0d result transfers", items_sent, results_seen);
      $display("including error codes, interrupted loads, a full list and a stalled result side");
      if (mismatch_count == 0) begin
         $display("tb_positional_list_insert_delete_top passed");
      end else begin
         $display("%0d result mismatches", mismatch_count);
         $display("tb_positional_list_insert_delete_top failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/plid_pkg.sv
sv/plid_front.sv
sv/plid_queue.sv
sv/plid_back.sv
sv/positional_list_insert_delete_top.sv
tb/sv/plid_list_checker.sv
tb/sv/tb_positional_list_insert_delete_top.sv
